### sv/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// shared widths, op codes, sequencer mode type and the beat structs
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int OP_W    = 2;
  localparam int TIME_W  = 16;
  localparam int COUNT_W = 8;

  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_BEEP    = 2'd1;
  localparam logic [OP_W-1:0] OP_PATTERN = 2'd2;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_BEEP    = 2'd1,
    MODE_PATTERN = 2'd2
  } mode_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [TIME_W-1:0]  beep_duration;
    logic [COUNT_W-1:0] beep_count;
    logic [TIME_W-1:0]  on_time;
    logic [TIME_W-1:0]  off_time;
  } item_t;

  typedef struct packed {
    logic buzzer_level;
    logic active;
  } result_t;

endpackage

### sv/beep_pattern_sequencer_unit.sv
// ----------------------------------------------------------------------------
// beep_pattern_sequencer_unit
// buzzer sequencer: ticks, single beeps and beep patterns, one result per beat
// ----------------------------------------------------------------------------
//
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   op, beep_duration, beep_count,
//                                           on_time, off_time
// out      output     out_valid / out_ready buzzer_level, active
// cfg      input      cfg_valid / cfg_ready cfg_enable
//
// one beat per cycle sustained while the out side keeps out_ready high; a beat
// passes through the input register and then the result register
// the only loop is the sequencer state update
// rst is synchronous: clears both pipeline stages, idles the sequencer and
// sets enable to 1
// a stalled out side holds the result register; the input register keeps
// taking beats as long as the result register is free or being drained
// cfg beats wait until both pipeline stages are empty
//
module beep_pattern_sequencer_unit (
  input  logic                        clk,
  input  logic                        rst,

  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bps_pkg::OP_W-1:0]    op,
  input  logic [bps_pkg::TIME_W-1:0]  beep_duration,
  input  logic [bps_pkg::COUNT_W-1:0] beep_count,
  input  logic [bps_pkg::TIME_W-1:0]  on_time,
  input  logic [bps_pkg::TIME_W-1:0]  off_time,

  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        buzzer_level,
  output logic                        active,

  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_enable
);
  import bps_pkg::*;

  // enable register, writes only land while both pipeline stages are empty
  logic    enable;

  // input register stage
  logic    item_valid;
  item_t   item;

  // result register stage
  result_t result_next;
  result_t result;

  // item in the input register moves on once the result slot is free or being drained
  logic    step;

  assign step      = item_valid && (!out_valid || out_ready);
  assign in_ready  = !item_valid || step;
  // nothing in flight in either stage
  assign cfg_ready = !item_valid && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      enable <= cfg_enable;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.op            <= op;
      item.beep_duration <= beep_duration;
      item.beep_count    <= beep_count;
      item.on_time       <= on_time;
      item.off_time      <= off_time;
    end
  end

  // sequencer state and its update
  bps_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .enable (enable),
    .item   (item),
    .result (result_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= result_next;
    end
  end

  assign buzzer_level = result.buzzer_level;
  assign active       = result.active;

endmodule

### sv/bps_core.sv
// ----------------------------------------------------------------------------
// bps_core
// sequencer state and its update for one beat; result is the state after it
// ----------------------------------------------------------------------------
module bps_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic            enable,
  input  bps_pkg::item_t  item,
  output bps_pkg::result_t result
);
  import bps_pkg::*;

  mode_t              mode, mode_next;
  logic               drive_level, drive_level_next;
  logic [TIME_W-1:0]  elapsed_ms, elapsed_ms_next;
  logic [TIME_W-1:0]  interval_ms, interval_ms_next;
  logic [COUNT_W-1:0] total_beeps, total_beeps_next;
  logic [COUNT_W-1:0] beeps_done, beeps_done_next;
  logic [TIME_W-1:0]  saved_on_ms, saved_on_ms_next;
  logic [TIME_W-1:0]  saved_off_ms, saved_off_ms_next;
  logic               phase_on, phase_on_next;

  logic [TIME_W-1:0]  elapsed_inc;
  logic [COUNT_W-1:0] done_inc;
  logic               expired;

  // saturating millisecond count and interval compare
  assign elapsed_inc = (elapsed_ms == TIME_MAX) ? elapsed_ms : elapsed_ms + 1'b1;
  assign expired     = (elapsed_inc >= interval_ms);
  assign done_inc    = beeps_done + 1'b1;

  // next state
  always_comb begin
    mode_next         = mode;
    drive_level_next  = drive_level;
    elapsed_ms_next   = elapsed_ms;
    interval_ms_next  = interval_ms;
    total_beeps_next  = total_beeps;
    beeps_done_next   = beeps_done;
    saved_on_ms_next  = saved_on_ms;
    saved_off_ms_next = saved_off_ms;
    phase_on_next     = phase_on;
    case (item.op)
      OP_TICK: begin
        if (!enable && mode != MODE_IDLE) begin
          drive_level_next = 1'b0;
          mode_next        = MODE_IDLE;
        end else begin
          elapsed_ms_next = elapsed_inc;
          if (expired) begin
            case (mode)
              MODE_BEEP: begin
                drive_level_next = 1'b0;
                mode_next        = MODE_IDLE;
              end
              MODE_PATTERN: begin
                if (phase_on) begin
                  drive_level_next = 1'b0;
                  beeps_done_next  = done_inc;
                  if (done_inc >= total_beeps) begin
                    mode_next = MODE_IDLE;
                  end else begin
                    phase_on_next    = 1'b0;
                    interval_ms_next = saved_off_ms;
                    elapsed_ms_next  = '0;
                  end
                end else begin
                  phase_on_next    = 1'b1;
                  drive_level_next = 1'b1;
                  interval_ms_next = saved_on_ms;
                  elapsed_ms_next  = '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      OP_BEEP: begin
        if (enable && mode == MODE_IDLE) begin
          drive_level_next = 1'b1;
          interval_ms_next = item.beep_duration;
          elapsed_ms_next  = '0;
          mode_next        = MODE_BEEP;
        end
      end
      OP_PATTERN: begin
        if (enable && item.beep_count != '0 && mode == MODE_IDLE) begin
          total_beeps_next  = item.beep_count;
          beeps_done_next   = '0;
          saved_on_ms_next  = item.on_time;
          saved_off_ms_next = item.off_time;
          drive_level_next  = 1'b1;
          interval_ms_next  = item.on_time;
          elapsed_ms_next   = '0;
          mode_next         = MODE_PATTERN;
          phase_on_next     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    result.buzzer_level = drive_level_next;
    result.active       = (mode_next != MODE_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      drive_level  <= 1'b0;
      elapsed_ms   <= '0;
      interval_ms  <= '0;
      total_beeps  <= '0;
      beeps_done   <= '0;
      saved_on_ms  <= '0;
      saved_off_ms <= '0;
      phase_on     <= 1'b0;
    end else if (step) begin
      mode         <= mode_next;
      drive_level  <= drive_level_next;
      elapsed_ms   <= elapsed_ms_next;
      interval_ms  <= interval_ms_next;
      total_beeps  <= total_beeps_next;
      beeps_done   <= beeps_done_next;
      saved_on_ms  <= saved_on_ms_next;
      saved_off_ms <= saved_off_ms_next;
      phase_on     <= phase_on_next;
    end
  end

endmodule
